>>> rtl/rv64_pkg.sv
// Shared types, codes and decode helpers for the RV64I integer core.
// No dependencies.
`default_nettype none
package rv64_pkg;
  localparam int unsigned XLEN = 64;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned REG_AW = 5;
  localparam logic [31:0] HALT_WORD = 32'hfeedfeed;
  localparam logic [31:0] NOP_WORD = 32'h0000_0013;
  localparam logic [6:0] F7_ALT = 7'b0100000;
  localparam logic [31:0] U_IMM_MASK = 32'hFFFFF000;

  localparam logic [2:0] KIND_RETIRED = 3'd0;
  localparam logic [2:0] KIND_LOAD_REQ = 3'd1;
  localparam logic [2:0] KIND_STORE_REQ = 3'd2;
  localparam logic [2:0] KIND_LOAD_DONE = 3'd3;
  localparam logic [2:0] KIND_HALT = 3'd4;
  localparam logic [2:0] KIND_ILLEGAL = 3'd5;
  localparam logic [2:0] KIND_UNEXPECTED = 3'd6;

  localparam logic [6:0] OP_IMM = 7'h13;
  localparam logic [6:0] OP_IMM32 = 7'h1B;
  localparam logic [6:0] OP_REG = 7'h33;
  localparam logic [6:0] OP_REG32 = 7'h3B;
  localparam logic [6:0] OP_LUI = 7'h37;
  localparam logic [6:0] OP_PC_UPPER = 7'h17;
  localparam logic [6:0] OP_JAL = 7'h6F;
  localparam logic [6:0] OP_JALR = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD = 7'h03;
  localparam logic [6:0] OP_MEM_WRITE = 7'h23;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] next_pc;
    logic [63:0] mem_address;
    logic [1:0]  mem_size_log2;
    logic [63:0] store_data;
    logic        rd_written;
    logic [4:0]  rd_index;
    logic [63:0] rd_value;
  } result_t;

  function automatic logic [63:0] size_mask(input logic [1:0] lg);
    case (lg)
      2'd0: size_mask = 64'h0000_0000_0000_00FF;
      2'd1: size_mask = 64'h0000_0000_0000_FFFF;
      2'd2: size_mask = 64'h0000_0000_FFFF_FFFF;
      default: size_mask = '1;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/rv64i_integer_core_top.sv
// Top level of the RV64I integer core: register file, execute stage, output register.
// Depends on rv64_pkg, rv64_regfile, rv64_exec.
//
//  channel | dir | tuser        | tdata
//  s_axis  | in  | action[0]    | instruction_word[31:0], load_data[95:32]
//  m_axis  | out | kind[2:0]    | next_pc .. rd_value, 264 bits
//
// One item per cycle: stage 1 registers the request and reads the register file,
// stage 2 executes and writes back; the output register holds the result.
// A result is registered into the output register when stage 2 advances.
// A write in stage 2 is forwarded to a read of the same register in stage 1.
// Reset clears the control state at once. A stalled output holds both stages.
`default_nettype none
module rv64i_integer_core_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // action[0]
  input  wire logic         s_axis_tuser,
  // instruction_word[31:0], load_data[95:32]
  input  wire logic [95:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // kind[2:0]
  output logic [2:0]        m_axis_tuser,
  // next_pc[63:0], mem_address[127:64], mem_size_log2[129:128],
  // store_data[193:130], rd_written[194], rd_index[199:195], rd_value[263:200]
  output logic [263:0]      m_axis_tdata
);
  logic v1_q, out_v_q, adv1, adv2;
  logic act_q;
  logic [31:0] w_q;
  logic [63:0] ld_q, pc_q, a_rf, b_rf, a_fw, b_fw;
  logic lwait_q, stopped_q;
  logic [4:0] ldest_q;
  logic [2:0] lvar_q;
  rv64_pkg::result_t res, out_q;
  logic stop, lset, lclr, pcwe;

  assign adv2 = v1_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !v1_q || adv2;
  assign adv1 = s_axis_tvalid && s_axis_tready;

  rv64_regfile u_rf (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .ra_i(s_axis_tdata[19:15]), .rb_i(s_axis_tdata[24:20]),
    .a_o(a_rf), .b_o(b_rf),
    .we_i(adv2 && res.rd_written), .wa_i(res.rd_index), .wd_i(res.rd_value)
  );

  logic fwa_q, fwb_q;
  logic [63:0] fwd_q;
  logic [63:0] hold_av_q, hold_bv_q;
  logic hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; out_v_q <= 1'b0; pc_q <= '0; lwait_q <= 1'b0;
      ldest_q <= '0; lvar_q <= '0; stopped_q <= 1'b0;
      fwa_q <= 1'b0; fwb_q <= 1'b0; hold_q <= 1'b0;
    end else begin
      if (adv2 || (out_v_q && m_axis_tready)) out_v_q <= adv2;
      if (adv1) v1_q <= 1'b1;
      else if (adv2) v1_q <= 1'b0;
      hold_q <= v1_q && !adv2;
      fwa_q <= adv2 && res.rd_written && (res.rd_index == s_axis_tdata[19:15]);
      fwb_q <= adv2 && res.rd_written && (res.rd_index == s_axis_tdata[24:20]);
      if (adv2) begin
        if (pcwe) pc_q <= res.next_pc;
        if (stop) stopped_q <= 1'b1;
        if (lset) begin
          lwait_q <= 1'b1; ldest_q <= w_q[11:7]; lvar_q <= w_q[14:12];
        end
        if (lclr) lwait_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      act_q <= s_axis_tuser; w_q <= s_axis_tdata[31:0]; ld_q <= s_axis_tdata[95:32];
    end
    fwd_q <= res.rd_value;
    hold_av_q <= a_fw; hold_bv_q <= b_fw;
    if (adv2) out_q <= res;
  end

  assign a_fw = hold_q ? hold_av_q : (fwa_q ? fwd_q : a_rf);
  assign b_fw = hold_q ? hold_bv_q : (fwb_q ? fwd_q : b_rf);

  rv64_exec u_ex (
    .action_i(act_q), .w_i(w_q), .ldata_i(ld_q), .a_i(a_fw), .b_i(b_fw), .pc_i(pc_q),
    .lwait_i(lwait_q), .ldest_i(ldest_q), .lvar_i(lvar_q), .stopped_i(stopped_q),
    .res_o(res), .stop_o(stop), .lset_o(lset), .lclr_o(lclr), .pc_we_o(pcwe)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser = out_q.kind;
  assign m_axis_tdata = {out_q.rd_value, out_q.rd_index, out_q.rd_written,
                         out_q.store_data, out_q.mem_size_log2, out_q.mem_address,
                         out_q.next_pc};
endmodule
`default_nettype wire

>>> rtl/rv64_regfile.sv
// 32 x 64 register file, one write port, two synchronous read ports.
// Valid bits give the reset value of zero; depends on rv64_pkg.
`default_nettype none
module rv64_regfile (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [rv64_pkg::REG_AW-1:0] ra_i,
  input  wire logic [rv64_pkg::REG_AW-1:0] rb_i,
  output logic [rv64_pkg::XLEN-1:0]       a_o,
  output logic [rv64_pkg::XLEN-1:0]       b_o,
  input  wire logic                       we_i,
  input  wire logic [rv64_pkg::REG_AW-1:0] wa_i,
  input  wire logic [rv64_pkg::XLEN-1:0]  wd_i
);
  logic [rv64_pkg::XLEN-1:0] mem [rv64_pkg::REG_COUNT];
  logic [rv64_pkg::REG_COUNT-1:0] vld_q;
  logic [rv64_pkg::XLEN-1:0] a_q, b_q;
  logic va_q, vb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[wa_i] <= wd_i;
    a_q <= mem[ra_i];
    b_q <= mem[rb_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (we_i) vld_q[wa_i] <= 1'b1;
      va_q <= vld_q[ra_i] && (ra_i != '0);
      vb_q <= vld_q[rb_i] && (rb_i != '0);
    end
  end

  assign a_o = va_q ? a_q : '0;
  assign b_o = vb_q ? b_q : '0;
endmodule
`default_nettype wire

>>> rtl/rv64_exec.sv
// Decode, legality check and execute for one item, combinational.
// Depends on rv64_pkg.
`default_nettype none
module rv64_exec (
  input  wire logic        action_i,
  input  wire logic [31:0] w_i,
  input  wire logic [63:0] ldata_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  input  wire logic [63:0] pc_i,
  input  wire logic        lwait_i,
  input  wire logic [4:0]  ldest_i,
  input  wire logic [2:0]  lvar_i,
  input  wire logic        stopped_i,
  output rv64_pkg::result_t res_o,
  output logic             stop_o,
  output logic             lset_o,
  output logic             lclr_o,
  output logic             pc_we_o
);
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [4:0] rd, rs2;
  logic [63:0] i_imm, s_imm, u_imm, j_imm, b_imm, val, npc, addr, sdata, opb, ldv, r64;
  logic [31:0] r32, lo;
  logic [5:0] sh;
  logic alt, legal, writes, taken, lt, ltu;
  logic [2:0] kind;

  always_comb begin
    op = w_i[6:0]; rd = w_i[11:7]; f3 = w_i[14:12]; rs2 = w_i[24:20]; f7 = w_i[31:25];
    i_imm = {{52{w_i[31]}}, w_i[31:20]};
    s_imm = {{52{w_i[31]}}, w_i[31:25], w_i[11:7]};
    u_imm = {{32{w_i[31]}}, w_i[31:12], 12'h000};
    j_imm = {{44{w_i[31]}}, w_i[19:12], w_i[20], w_i[30:21], 1'b0};
    b_imm = {{52{w_i[31]}}, w_i[7], w_i[30:25], w_i[11:8], 1'b0};
    lt = $signed(a_i) < $signed(b_i);
    ltu = a_i < b_i;
    legal = 1'b1; writes = 1'b0; taken = 1'b0;
    kind = rv64_pkg::KIND_RETIRED;
    npc = pc_i + 64'd4; addr = '0; sdata = '0; val = '0;
    alt = 1'b0; opb = b_i; r64 = '0; r32 = '0; lo = a_i[31:0]; sh = '0;
    case (op)
      rv64_pkg::OP_IMM, rv64_pkg::OP_REG: begin
        writes = 1'b1;
        if (op == rv64_pkg::OP_IMM) begin
          opb = ((f3 == 3'd1) || (f3 == 3'd5)) ? {58'd0, w_i[25], rs2} : i_imm;
          alt = ((f3 == 3'd5) && f7[5]);
          if (f3 == 3'd1) legal = (f7[6:1] == 6'd0);
          else if (f3 == 3'd5) legal = (f7[6:1] == 6'd0) || (f7[6:1] == rv64_pkg::F7_ALT[6:1]);
        end else begin
          alt = (f7 == rv64_pkg::F7_ALT);
          if (f3 == 3'd0 || f3 == 3'd5) legal = (f7 == 7'd0) || alt;
          else legal = (f7 == 7'd0);
        end
        sh = opb[5:0];
        case (f3)
          3'd0: r64 = alt ? a_i - opb : a_i + opb;
          3'd1: r64 = a_i << sh;
          3'd2: r64 = {63'd0, $signed(a_i) < $signed(opb)};
          3'd3: r64 = {63'd0, a_i < opb};
          3'd4: r64 = a_i ^ opb;
          3'd5: r64 = alt ? 64'($signed(a_i) >>> sh) : a_i >> sh;
          3'd6: r64 = a_i | opb;
          default: r64 = a_i & opb;
        endcase
        val = r64;
      end
      rv64_pkg::OP_IMM32, rv64_pkg::OP_REG32: begin
        writes = 1'b1;
        if (op == rv64_pkg::OP_IMM32) begin
          opb = (f3 == 3'd0) ? i_imm : {59'd0, rs2};
          alt = (f3 == 3'd5) && (f7 == rv64_pkg::F7_ALT);
          if (f3 == 3'd1) legal = (f7 == 7'd0);
          else if (f3 == 3'd5) legal = (f7 == 7'd0) || alt;
          else if (f3 != 3'd0) legal = 1'b0;
        end else begin
          alt = (f7 == rv64_pkg::F7_ALT);
          if (f3 == 3'd0 || f3 == 3'd5) legal = (f7 == 7'd0) || alt;
          else legal = (f3 == 3'd1) && (f7 == 7'd0);
        end
        sh = {1'b0, opb[4:0]};
        case (f3)
          3'd0: r32 = alt ? lo - opb[31:0] : lo + opb[31:0];
          3'd1: r32 = lo << sh[4:0];
          default: r32 = alt ? 32'($signed(lo) >>> sh[4:0]) : lo >> sh[4:0];
        endcase
        val = {{32{r32[31]}}, r32};
      end
      rv64_pkg::OP_LUI: begin
        writes = 1'b1; val = u_imm;
      end
      rv64_pkg::OP_PC_UPPER: begin
        writes = 1'b1; val = pc_i + u_imm;
      end
      rv64_pkg::OP_JAL: begin
        writes = 1'b1; val = pc_i + 64'd4; npc = pc_i + j_imm;
      end
      rv64_pkg::OP_JALR: begin
        legal = (f3 == 3'd0);
        writes = 1'b1; val = pc_i + 64'd4; npc = (a_i + i_imm) & ~64'd1;
      end
      rv64_pkg::OP_BRANCH: begin
        case (f3)
          3'd0: taken = (a_i == b_i);
          3'd1: taken = (a_i != b_i);
          3'd4: taken = lt;
          3'd5: taken = !lt;
          3'd6: taken = ltu;
          3'd7: taken = !ltu;
          default: legal = 1'b0;
        endcase
        if (taken) npc = pc_i + b_imm;
      end
      rv64_pkg::OP_LOAD: begin
        legal = (f3 != 3'd7);
        kind = rv64_pkg::KIND_LOAD_REQ; addr = a_i + i_imm;
      end
      rv64_pkg::OP_MEM_WRITE: begin
        legal = !f3[2];
        kind = rv64_pkg::KIND_STORE_REQ; addr = a_i + s_imm;
        sdata = b_i & rv64_pkg::size_mask(f3[1:0]);
      end
      default: legal = 1'b0;
    endcase

    ldv = ldata_i & rv64_pkg::size_mask(lvar_i[1:0]);
    if (!lvar_i[2]) begin
      case (lvar_i[1:0])
        2'd0: ldv = {{56{ldv[7]}}, ldv[7:0]};
        2'd1: ldv = {{48{ldv[15]}}, ldv[15:0]};
        2'd2: ldv = {{32{ldv[31]}}, ldv[31:0]};
        default: ldv = ldv;
      endcase
    end

    res_o = '0;
    res_o.next_pc = pc_i;
    stop_o = 1'b0; lset_o = 1'b0; lclr_o = 1'b0; pc_we_o = 1'b0;
    if (stopped_i || (action_i != lwait_i)) begin
      res_o.kind = rv64_pkg::KIND_UNEXPECTED;
    end else if (action_i) begin
      res_o.kind = rv64_pkg::KIND_LOAD_DONE;
      lclr_o = 1'b1;
      if (ldest_i != 5'd0) begin
        res_o.rd_written = 1'b1; res_o.rd_index = ldest_i; res_o.rd_value = ldv;
      end
    end else if (w_i == rv64_pkg::HALT_WORD) begin
      res_o.kind = rv64_pkg::KIND_HALT; stop_o = 1'b1;
    end else if (!legal) begin
      res_o.kind = rv64_pkg::KIND_ILLEGAL; stop_o = 1'b1;
    end else begin
      res_o.kind = kind; res_o.next_pc = npc; res_o.mem_address = addr;
      res_o.mem_size_log2 = (kind == rv64_pkg::KIND_RETIRED) ? 2'd0 : f3[1:0];
      res_o.store_data = sdata;
      pc_we_o = 1'b1;
      lset_o = (kind == rv64_pkg::KIND_LOAD_REQ);
      if (writes && rd != 5'd0) begin
        res_o.rd_written = 1'b1; res_o.rd_index = rd; res_o.rd_value = val;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/rv64_checker.sv
// Port-level checks for rv64i_integer_core_top, bound to the top level.
// Depends on rv64_pkg for result codes.
`default_nettype none
module rv64_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [2:0]   m_axis_tuser,
  input wire logic [263:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped under stall");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= rv64_pkg::KIND_UNEXPECTED)
    else $error("bad kind");
  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[194] |-> m_axis_tdata[199:195] != 5'd0)
    else $error("write to x0 reported");
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == rv64_pkg::KIND_HALT |-> !m_axis_tdata[194])
    else $error("halt wrote a register");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("ready lost");
endmodule

bind rv64i_integer_core_top rv64_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
